// ----- hdl/ccs_pkg.sv -----
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types, register indexes, effect codes and small arithmetic helpers
// for the cell color effect shader.
// ----------------------------------------------------------------------------
package ccs_pkg;

  // largest area size in cells; larger settings are taken as this
  localparam int MAX_AREA_DIM = 4096;

  localparam int NUM_W = 35;
  localparam int DEN_W = 34;
  localparam int QUO_W = 12;

  localparam logic [2:0] CFG_SELECT   = 3'd0;
  localparam logic [2:0] CFG_STRENGTH = 3'd1;
  localparam logic [2:0] CFG_COLOR    = 3'd2;
  localparam logic [2:0] CFG_PARAM    = 3'd3;
  localparam logic [2:0] CFG_COLS     = 3'd4;
  localparam logic [2:0] CFG_ROWS     = 3'd5;
  localparam logic [2:0] CFG_CURSOR   = 3'd6;
  localparam logic [2:0] CFG_DEFAULTS = 3'd7;

  localparam logic [3:0] EFF_DIM      = 4'd0;
  localparam logic [3:0] EFF_GRAY     = 4'd1;
  localparam logic [3:0] EFF_TINT     = 4'd2;
  localparam logic [3:0] EFF_VIGNETTE = 4'd3;
  localparam logic [3:0] EFF_GRADIENT = 4'd4;
  localparam logic [3:0] EFF_ZEBRA    = 4'd5;
  localparam logic [3:0] EFF_RULER    = 4'd6;
  localparam logic [3:0] EFF_MARGIN   = 4'd7;
  localparam logic [3:0] EFF_SPOT     = 4'd8;

  localparam logic [15:0] GRAD_UP         = 16'd1;
  localparam logic [15:0] GRAD_LTR        = 16'd2;
  localparam logic [15:0] GRAD_RTL        = 16'd3;
  localparam logic [15:0] SPOT_RADIUS_DEF = 16'd10;

  localparam logic [7:0] LUMA_R = 8'd77;
  localparam logic [7:0] LUMA_G = 8'd150;
  localparam logic [7:0] LUMA_B = 8'd29;
  localparam logic [7:0] FULL   = 8'd255;

  typedef struct packed {
    logic [5:0]  select;
    logic [7:0]  strength;
    logic [23:0] color;
    logic [15:0] param;
    logic [12:0] cols;
    logic [12:0] rows;
    logic [24:0] cursor;
    logic [47:0] defaults;
  } cfg_t;

  typedef struct packed {
    logic        pass;
    logic        fp0;
    logic [23:0] fc0;
    logic        bp0;
    logic [23:0] bc0;
    logic [23:0] fc;
    logic [23:0] bc;
  } cell_t;

  typedef struct packed {
    logic ruler_hit;
    logic margin_hit;
    logic use_q;
  } hit_t;

  typedef struct packed {
    cell_t body;
    hit_t  hit;
  } item_t;

  // exact x/255 for x up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    logic [16:0] s;
    t = {1'b0, x} + 17'd1;
    s = t + (t >> 8);
    return s[15:8];
  endfunction

  function automatic logic [15:0] blend8(input logic [7:0] from, input logic [7:0] to,
                                         input logic [7:0] a);
    logic [15:0] p0;
    logic [15:0] p1;
    p0 = 16'(from) * 16'(FULL - a);
    p1 = 16'(to) * 16'(a);
    return p0 + p1;
  endfunction

  function automatic logic [7:0] luma(input logic [23:0] c);
    logic [15:0] s;
    s = 16'(c[23:16]) * 16'(LUMA_R) + 16'(c[15:8]) * 16'(LUMA_G) + 16'(c[7:0]) * 16'(LUMA_B);
    return s[15:8];
  endfunction

endpackage

// ----- hdl/ccs_geom.sv -----
// ----------------------------------------------------------------------------
// ccs_geom
// Front pipeline: default fill, cell distances, gradient position, and the
// dividend and divisor for the shared divider.
// ----------------------------------------------------------------------------
module ccs_geom import ccs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  cfg_t             cfg,
  input  logic             in_valid,
  input  logic [11:0]      in_col,
  input  logic [11:0]      in_row,
  input  logic             in_fp,
  input  logic [23:0]      in_fc,
  input  logic             in_bp,
  input  logic [23:0]      in_bc,
  input  logic             in_tail,
  output logic             out_valid,
  output item_t            out_item,
  output logic [NUM_W-1:0] out_num,
  output logic [DEN_W-1:0] out_den
);

  logic [3:0]  eff;
  logic [7:0]  a;
  logic [11:0] cx, cy;
  logic [15:0] rad;

  assign eff = cfg.select[3:0];
  assign a   = cfg.strength;
  assign cx  = cfg.cols[12:1];
  assign cy  = cfg.rows[12:1];
  assign rad = (cfg.param == 16'd0) ? SPOT_RADIUS_DEF : cfg.param;

  // settings-derived terms, static while cells flow
  logic [23:0] cxsq_r;
  logic [25:0] cy4sq_r;
  logic [31:0] inner_r;
  logic [24:0] far_r;
  logic [33:0] ramp_r;

  always_ff @(posedge clk) begin
    cxsq_r  <= 24'(cx) * 24'(cx);
    cy4sq_r <= (26'(cy) * 26'(cy)) << 2;
    inner_r <= 32'(rad) * 32'(rad);
    far_r   <= 25'(cxsq_r) + 25'(cy4sq_r);
    ramp_r  <= (34'(inner_r) << 1) + 34'(inner_r);
  end

  // stage 1 inputs
  logic signed [13:0] dx_c, dy_c, pos_c;
  logic [12:0] span_c, spm1_c;
  logic [11:0] gpos_c;
  cell_t       cell_c;

  always_comb begin
    if (eff == EFF_SPOT) begin
      dx_c = $signed({2'b0, in_col}) - $signed({2'b0, cfg.cursor[11:0]});
      dy_c = $signed({2'b0, in_row}) - $signed({2'b0, cfg.cursor[23:12]});
    end else begin
      dx_c = $signed({2'b0, in_col}) - $signed({2'b0, cx});
      dy_c = $signed({2'b0, in_row}) - $signed({2'b0, cy});
    end
    case (cfg.param)
      GRAD_UP: begin
        span_c = cfg.rows;
        pos_c  = $signed({1'b0, cfg.rows}) - 14'sd1 - $signed({2'b0, in_row});
      end
      GRAD_LTR: begin
        span_c = cfg.cols;
        pos_c  = $signed({2'b0, in_col});
      end
      GRAD_RTL: begin
        span_c = cfg.cols;
        pos_c  = $signed({1'b0, cfg.cols}) - 14'sd1 - $signed({2'b0, in_col});
      end
      default: begin
        span_c = cfg.rows;
        pos_c  = $signed({2'b0, in_row});
      end
    endcase
    spm1_c = span_c - 13'd1;
    if (pos_c < 14'sd0) begin
      gpos_c = 12'd0;
    end else if (pos_c > $signed({1'b0, spm1_c})) begin
      gpos_c = spm1_c[11:0];
    end else begin
      gpos_c = pos_c[11:0];
    end
    cell_c.pass = in_tail || (eff > EFF_SPOT);
    cell_c.fp0  = in_fp;
    cell_c.fc0  = in_fc;
    cell_c.bp0  = in_bp;
    cell_c.bc0  = in_bc;
    cell_c.fc   = in_fp ? in_fc : cfg.defaults[23:0];
    cell_c.bc   = in_bp ? in_bc : cfg.defaults[47:24];
  end

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  item_t it1_r, it2_r, it3_r, it4_r, it5_r;
  logic [11:0] y1_r, y2_r, y3_r, y4_r;
  logic [11:0] gden1_r, gden2_r, gden3_r, gden4_r;
  logic gok1_r, gok2_r, gok3_r, gok4_r;
  logic signed [13:0] dx1_r, dy1_r;
  logic [11:0] gpos1_r;
  logic [23:0] dxsq2_r;
  logic [25:0] dy4sq2_r;
  logic [19:0] gnum2_r, gnum3_r, gnum4_r;
  logic [26:0] d3_r;
  logic [24:0] dcap4_r;
  logic [26:0] over4_r;
  logic        hit4_r;
  logic [NUM_W-1:0] num5_r;
  logic [DEN_W-1:0] den5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  logic signed [27:0] dxp, dyp;
  logic [26:0] overc;
  item_t it5_nxt;
  logic [NUM_W-1:0] num5_nxt;
  logic [DEN_W-1:0] den5_nxt;

  assign dxp   = dx1_r * dx1_r;
  assign dyp   = dy1_r * dy1_r;
  assign overc = (34'(over4_r) >= ramp_r) ? ramp_r[26:0] : over4_r;

  always_comb begin
    it5_nxt           = it4_r;
    it5_nxt.hit.use_q = 1'b0;
    num5_nxt          = '0;
    den5_nxt          = DEN_W'(1);
    case (eff)
      EFF_VIGNETTE: begin
        if (far_r != 25'd0) begin
          it5_nxt.hit.use_q = 1'b1;
          num5_nxt          = NUM_W'(33'(a) * 33'(dcap4_r));
          den5_nxt          = DEN_W'(far_r);
        end
      end
      EFF_GRADIENT: begin
        if (gok4_r) begin
          it5_nxt.hit.use_q = 1'b1;
          num5_nxt          = NUM_W'(gnum4_r);
          den5_nxt          = DEN_W'(gden4_r);
        end
      end
      EFF_ZEBRA: begin
        it5_nxt.hit.use_q = 1'b1;
        num5_nxt          = NUM_W'(y4_r);
        den5_nxt          = (cfg.param == 16'd0) ? DEN_W'(1) : DEN_W'(cfg.param);
      end
      EFF_SPOT: begin
        if (cfg.cursor[24] && hit4_r) begin
          it5_nxt.hit.use_q = 1'b1;
          num5_nxt          = (NUM_W'(overc) << 8) - NUM_W'(overc);
          den5_nxt          = ramp_r;
        end
      end
      default: begin
        it5_nxt.hit.use_q = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1_r.body           <= cell_c;
      it1_r.hit.ruler_hit  <= {4'b0, in_col} == cfg.param;
      it1_r.hit.margin_hit <= {4'b0, in_col} >= cfg.param;
      it1_r.hit.use_q      <= 1'b0;
      y1_r    <= in_row;
      gden1_r <= spm1_c[11:0];
      gok1_r  <= span_c > 13'd1;
      dx1_r   <= dx_c;
      dy1_r   <= dy_c;
      gpos1_r <= gpos_c;

      it2_r    <= it1_r;
      y2_r     <= y1_r;
      gden2_r  <= gden1_r;
      gok2_r   <= gok1_r;
      dxsq2_r  <= dxp[23:0];
      dy4sq2_r <= {dyp[23:0], 2'b00};
      gnum2_r  <= 20'(a) * 20'(gpos1_r);

      it3_r   <= it2_r;
      y3_r    <= y2_r;
      gden3_r <= gden2_r;
      gok3_r  <= gok2_r;
      gnum3_r <= gnum2_r;
      d3_r    <= 27'(dxsq2_r) + 27'(dy4sq2_r);

      it4_r   <= it3_r;
      y4_r    <= y3_r;
      gden4_r <= gden3_r;
      gok4_r  <= gok3_r;
      gnum4_r <= gnum3_r;
      dcap4_r <= (d3_r > 27'(far_r)) ? far_r : d3_r[24:0];
      hit4_r  <= 32'(d3_r) > inner_r;
      over4_r <= 27'(32'(d3_r) - inner_r);

      it5_r  <= it5_nxt;
      num5_r <= num5_nxt;
      den5_r <= den5_nxt;
    end
  end

  assign out_valid = v5_r;
  assign out_item  = it5_r;
  assign out_num   = num5_r;
  assign out_den   = den5_r;

endmodule

// ----- hdl/ccs_div.sv -----
// ----------------------------------------------------------------------------
// ccs_div
// Pipelined restoring divider, one quotient bit per stage; the quotient is
// known to fit in QUO_W bits.
// ----------------------------------------------------------------------------
module ccs_div import ccs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  item_t            in_item,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  output logic             out_valid,
  output item_t            out_item,
  output logic [QUO_W-1:0] out_quo
);

  localparam int SH_W = DEN_W + QUO_W - 1;

  logic             v_r   [QUO_W];
  item_t            it_r  [QUO_W];
  logic [NUM_W-1:0] rem_r [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int B = QUO_W - 1 - k;
    logic             pv;
    item_t            pit;
    logic [NUM_W-1:0] prem;
    logic [DEN_W-1:0] pden;
    logic [QUO_W-1:0] pquo;
    logic [SH_W-1:0]  sh;
    logic             ge;

    if (k == 0) begin : g_first
      assign pv   = in_valid;
      assign pit  = in_item;
      assign prem = in_num;
      assign pden = in_den;
      assign pquo = '0;
    end else begin : g_next
      assign pv   = v_r[k-1];
      assign pit  = it_r[k-1];
      assign prem = rem_r[k-1];
      assign pden = den_r[k-1];
      assign pquo = quo_r[k-1];
    end

    assign sh = SH_W'(pden) << B;
    assign ge = SH_W'(prem) >= sh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        it_r[k]  <= pit;
        den_r[k] <= pden;
        rem_r[k] <= ge ? NUM_W'(SH_W'(prem) - sh) : prem;
        quo_r[k] <= ge ? (pquo | (QUO_W'(1) << B)) : pquo;
      end
    end
  end

  assign out_valid = v_r[QUO_W-1];
  assign out_item  = it_r[QUO_W-1];
  assign out_quo   = quo_r[QUO_W-1];

endmodule

// ----- hdl/ccs_shade.sv -----
// ----------------------------------------------------------------------------
// ccs_shade
// Back pipeline: picks blend amount and target per color, blends each
// channel, divides by 255 and applies the keep mask into the output register.
// ----------------------------------------------------------------------------
module ccs_shade import ccs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  cfg_t             cfg,
  input  logic             in_valid,
  input  item_t            in_item,
  input  logic [QUO_W-1:0] in_quo,
  output logic             out_valid,
  output logic             out_fp,
  output logic [23:0]      out_fc,
  output logic             out_bp,
  output logic [23:0]      out_bc
);

  logic [3:0] eff;
  logic [7:0] a;
  assign eff = cfg.select[3:0];
  assign a   = cfg.strength;

  logic v1_r, v2_r, v3_r, v4_r;
  item_t it1_r;
  cell_t c2_r, c3_r;
  logic [QUO_W-1:0] q1_r;
  logic [15:0] sprod1_r;
  logic [7:0]  lumf1_r, lumb1_r;
  logic [7:0]  alf2_r, alb2_r;
  logic [23:0] tgf2_r, tgb2_r;
  logic [15:0] sf3_r [3];
  logic [15:0] sb3_r [3];
  logic        fp4_r, bp4_r;
  logic [23:0] fc4_r, bc4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  logic [7:0]  alf, alb;
  logic [23:0] tgf, tgb;

  // alpha 0 leaves a color exactly as it is
  always_comb begin
    alf = 8'd0;
    alb = 8'd0;
    tgf = 24'd0;
    tgb = 24'd0;
    case (eff)
      EFF_DIM: begin
        alf = a;
        alb = a;
      end
      EFF_GRAY: begin
        alf = a;
        alb = a;
        tgf = {3{lumf1_r}};
        tgb = {3{lumb1_r}};
      end
      EFF_TINT: begin
        alf = a;
        alb = a;
        tgf = cfg.color;
        tgb = cfg.color;
      end
      EFF_VIGNETTE: begin
        if (it1_r.hit.use_q) begin
          alf = q1_r[7:0];
          alb = q1_r[7:0];
        end
      end
      EFF_GRADIENT: begin
        if (it1_r.hit.use_q) begin
          alf = q1_r[7:0];
          alb = q1_r[7:0];
          tgf = cfg.defaults[47:24];
          tgb = cfg.defaults[47:24];
        end
      end
      EFF_ZEBRA: begin
        if (q1_r[0]) begin
          alf = a;
          alb = a;
        end
      end
      EFF_RULER: begin
        if (it1_r.hit.ruler_hit) begin
          alb = a;
          tgb = cfg.color;
        end
      end
      EFF_MARGIN: begin
        if (it1_r.hit.margin_hit) begin
          alf = a;
          alb = a;
        end
      end
      EFF_SPOT: begin
        if (it1_r.hit.use_q) begin
          alf = div255(sprod1_r);
          alb = div255(sprod1_r);
        end
      end
      default: begin
        alf = 8'd0;
      end
    endcase
  end

  logic keep_f, keep_b;
  logic [23:0] shf, shb;
  assign keep_f = (cfg.select[5:4] == 2'd0) || cfg.select[4];
  assign keep_b = (cfg.select[5:4] == 2'd0) || cfg.select[5];

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    assign shf[ch*8 +: 8] = div255(sf3_r[ch]);
    assign shb[ch*8 +: 8] = div255(sb3_r[ch]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1_r    <= in_item;
      q1_r     <= in_quo;
      sprod1_r <= 16'(a) * 16'(in_quo[7:0]);
      lumf1_r  <= luma(in_item.body.fc);
      lumb1_r  <= luma(in_item.body.bc);

      c2_r   <= it1_r.body;
      alf2_r <= alf;
      alb2_r <= alb;
      tgf2_r <= tgf;
      tgb2_r <= tgb;

      c3_r <= c2_r;
      for (int ch = 0; ch < 3; ch++) begin
        sf3_r[ch] <= blend8(c2_r.fc[ch*8 +: 8], tgf2_r[ch*8 +: 8], alf2_r);
        sb3_r[ch] <= blend8(c2_r.bc[ch*8 +: 8], tgb2_r[ch*8 +: 8], alb2_r);
      end

      if (c3_r.pass || !keep_f) begin
        fp4_r <= c3_r.fp0;
        fc4_r <= c3_r.fc0;
      end else begin
        fp4_r <= 1'b1;
        fc4_r <= shf;
      end
      if (c3_r.pass || !keep_b) begin
        bp4_r <= c3_r.bp0;
        bc4_r <= c3_r.bc0;
      end else begin
        bp4_r <= 1'b1;
        bc4_r <= shb;
      end
    end
  end

  assign out_valid = v4_r;
  assign out_fp    = fp4_r;
  assign out_fc    = fc4_r;
  assign out_bp    = bp4_r;
  assign out_bc    = bc4_r;

endmodule

// ----- hdl/cell_color_effect_shader_core.sv -----
// ----------------------------------------------------------------------------
// cell_color_effect_shader_core
// Applies one color effect to a stream of character cells.
// ----------------------------------------------------------------------------
// Takes one cell word per clock while in_tready is high and returns one
// shaded word per cell, in order, through 21 register stages: 5 geometry
// stages (distances, squares, dividend), a 12-stage shared divider, and 4
// blend stages ending in the output register. The whole pipeline advances
// together; in_tready drops only while the output word is held and
// out_tready is low. Area sizes above MAX_AREA_DIM are taken as
// MAX_AREA_DIM. Settings are to be written by the user only while no cell
// is in flight; the block itself does not enforce this.
module cell_color_effect_shader_core import ccs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // col, row, fg_present, fg_color, bg_present, bg_color, wide_tail, pad
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_fg_present, out_fg_color, out_bg_present, out_bg_color, pad
  output logic [55:0] out_tdata
);

  logic [5:0]  select_r;
  logic [7:0]  strength_r;
  logic [23:0] color_r;
  logic [15:0] param_r;
  logic [12:0] cols_r, rows_r;
  logic [24:0] cursor_r;
  logic [47:0] defaults_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      select_r   <= 6'd0;
      strength_r <= 8'd0;
      color_r    <= 24'd0;
      param_r    <= 16'd0;
      cols_r     <= 13'd80;
      rows_r     <= 13'd24;
      cursor_r   <= 25'd0;
      defaults_r <= 48'hFFFFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SELECT:   select_r   <= cfg_wdata[5:0];
        CFG_STRENGTH: strength_r <= cfg_wdata[7:0];
        CFG_COLOR:    color_r    <= cfg_wdata[23:0];
        CFG_PARAM:    param_r    <= cfg_wdata[15:0];
        CFG_COLS:     cols_r     <= cfg_wdata[12:0];
        CFG_ROWS:     rows_r     <= cfg_wdata[12:0];
        CFG_CURSOR:   cursor_r   <= cfg_wdata[24:0];
        CFG_DEFAULTS: defaults_r <= cfg_wdata;
        default:      select_r   <= select_r;
      endcase
    end
  end

  cfg_t cfg;
  always_comb begin
    cfg.select   = select_r;
    cfg.strength = strength_r;
    cfg.color    = color_r;
    cfg.param    = param_r;
    cfg.cols     = (32'(cols_r) > 32'(MAX_AREA_DIM)) ? 13'(MAX_AREA_DIM) : cols_r;
    cfg.rows     = (32'(rows_r) > 32'(MAX_AREA_DIM)) ? 13'(MAX_AREA_DIM) : rows_r;
    cfg.cursor   = cursor_r;
    cfg.defaults = defaults_r;
  end

  logic en;
  logic shade_valid;
  assign en        = !shade_valid || out_tready;
  assign in_tready = en;

  logic             geo_valid, div_valid;
  item_t            geo_item, div_item;
  logic [NUM_W-1:0] geo_num;
  logic [DEN_W-1:0] geo_den;
  logic [QUO_W-1:0] div_quo;

  ccs_geom u_geom (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .cfg      (cfg),
    .in_valid (in_tvalid),
    .in_col   (in_tdata[11:0]),
    .in_row   (in_tdata[23:12]),
    .in_fp    (in_tdata[24]),
    .in_fc    (in_tdata[48:25]),
    .in_bp    (in_tdata[49]),
    .in_bc    (in_tdata[73:50]),
    .in_tail  (in_tdata[74]),
    .out_valid(geo_valid),
    .out_item (geo_item),
    .out_num  (geo_num),
    .out_den  (geo_den)
  );

  ccs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (geo_valid),
    .in_item  (geo_item),
    .in_num   (geo_num),
    .in_den   (geo_den),
    .out_valid(div_valid),
    .out_item (div_item),
    .out_quo  (div_quo)
  );

  logic        o_fp, o_bp;
  logic [23:0] o_fc, o_bc;

  ccs_shade u_shade (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .cfg      (cfg),
    .in_valid (div_valid),
    .in_item  (div_item),
    .in_quo   (div_quo),
    .out_valid(shade_valid),
    .out_fp   (o_fp),
    .out_fc   (o_fc),
    .out_bp   (o_bp),
    .out_bc   (o_bc)
  );

  assign out_tvalid = shade_valid;
  assign out_tdata  = {6'd0, o_bc, o_bp, o_fc, o_fp};

endmodule

// ----- hdl/ccs_checker.sv -----
// ----------------------------------------------------------------------------
// ccs_checker
// Port-level checks on the shader stream handshake, bound to the top level.
// ----------------------------------------------------------------------------
module ccs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);

  // a held output word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // input side only backs up when the output word is stuck
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

endmodule

bind cell_color_effect_shader_core ccs_checker u_ccs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
